// File: hdl/ped_pkg.sv
package ped_pkg;

   // Defaults for the top-level parameters
   localparam int BLOCK_LEN_DEF   = 8192;
   localparam int SAMPLE_BITS_DEF = 16;

   // Extremum event queue between the front and back parts
   localparam int QUEUE_DEPTH = 4;

   // Fixed field widths
   localparam int CHAN_W    = 8;
   localparam int BASE_W    = 40;
   localparam int P2P_W     = 16;
   localparam int SPACING_W = 13;
   localparam int CSR_W     = 16;

   typedef enum logic [0:0] {
      CSR_MIN_P2P     = 1'b0,
      CSR_MIN_SPACING = 1'b1
   } csr_index_type;

endpackage

// File: hdl/plateau_extrema_pair_detector.sv
// Channel   | Direction | Handshake               | Payload
// req       | in        | req_push / req_full     | sample, block_first, channel_id, block_base
// rsp       | out       | rsp_pop / rsp_empty     | cand_channel, start_index, end_index,
//           |           |                         | peak_to_peak
// csr       | in        | csr_we (no wait)        | csr_index, csr_wdata
//
// One sample is taken every cycle while req_full is low; plateau tracking is done in the cycle of acceptance.
// A candidate reaches the rsp ports through the event queue and then the output register:
// the taking edge writes the queue; the back loads the output register when free or drained.
// Reset is synchronous and clears the plateau state, the queue and both thresholds.
// req_full rises only when the four-entry event queue is full, which takes a stalled
// rsp side; a sample that produces no candidate still waits for a free queue slot.
module plateau_extrema_pair_detector import ped_pkg::*; #(
   parameter int BLOCK_LEN   = BLOCK_LEN_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // Sample words
   input  logic                          req_push,
   output logic                          req_full,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   input  logic                          req_block_first,
   input  logic [CHAN_W-1:0]             req_channel_id,
   input  logic [BASE_W-1:0]             req_block_base,
   // Candidate words
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic [CHAN_W-1:0]             rsp_cand_channel,
   output logic [BASE_W-1:0]             rsp_start_index,
   output logic [BASE_W-1:0]             rsp_end_index,
   output logic [P2P_W-1:0]              rsp_peak_to_peak,
   // Threshold registers
   input  logic                          csr_we,
   input  logic [0:0]                    csr_index,
   input  logic [CSR_W-1:0]              csr_wdata
);

   localparam int POS_W = $clog2(BLOCK_LEN);
   localparam int EVT_W = CHAN_W + BASE_W + 2 * POS_W + 2 * SAMPLE_BITS;

   logic                          accept;
   logic                          f_push;
   logic [CHAN_W-1:0]             f_channel, b_channel;
   logic [BASE_W-1:0]             f_base, b_base;
   logic [POS_W-1:0]              f_prev_pos, b_prev_pos;
   logic [POS_W-1:0]              f_pos, b_pos;
   logic signed [SAMPLE_BITS-1:0] f_prev_value, b_prev_value;
   logic signed [SAMPLE_BITS-1:0] f_value, b_value;
   logic [EVT_W-1:0]              q_wdata, q_rdata;
   logic                          q_empty, q_pop;
   logic                          rsp_vld;

   assign accept = req_push && !req_full;

   // Front: track plateaus and classify extrema in the cycle a sample is taken
   ped_front #(
      .BLOCK_LEN   (BLOCK_LEN),
      .SAMPLE_BITS (SAMPLE_BITS),
      .POS_W       (POS_W)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .sample         (req_sample),
      .block_first    (req_block_first),
      .channel_id     (req_channel_id),
      .block_base     (req_block_base),
      .evt_push       (f_push),
      .evt_channel    (f_channel),
      .evt_base       (f_base),
      .evt_prev_pos   (f_prev_pos),
      .evt_pos        (f_pos),
      .evt_prev_value (f_prev_value),
      .evt_value      (f_value)
   );

   assign q_wdata = {f_channel, f_base, f_prev_pos, f_pos, f_prev_value, f_value};

   // Hold opposite-type extremum pairs until the back can judge them
   ped_queue #(
      .WIDTH (EVT_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (f_push),
      .wdata (q_wdata),
      .full  (req_full),
      .pop   (q_pop),
      .rdata (q_rdata),
      .empty (q_empty)
   );

   assign {b_channel, b_base, b_prev_pos, b_pos, b_prev_value, b_value} = q_rdata;

   // Back: apply thresholds, form global indices, present the candidate
   ped_back #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .POS_W       (POS_W)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .evt_vld          (!q_empty),
      .evt_channel      (b_channel),
      .evt_base         (b_base),
      .evt_prev_pos     (b_prev_pos),
      .evt_pos          (b_pos),
      .evt_prev_value   (b_prev_value),
      .evt_value        (b_value),
      .evt_pop          (q_pop),
      .rsp_vld          (rsp_vld),
      .rsp_pop          (rsp_pop),
      .rsp_cand_channel (rsp_cand_channel),
      .rsp_start_index  (rsp_start_index),
      .rsp_end_index    (rsp_end_index),
      .rsp_peak_to_peak (rsp_peak_to_peak)
   );

   assign rsp_empty = !rsp_vld;

endmodule

// File: hdl/ped_queue.sv
module ped_queue import ped_pkg::*; #(
   parameter int WIDTH = 8,
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign rdata   = store_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

// File: hdl/ped_front.sv
module ped_front import ped_pkg::*; #(
   parameter int BLOCK_LEN   = BLOCK_LEN_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   parameter int POS_W       = $clog2(BLOCK_LEN)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic signed [SAMPLE_BITS-1:0] sample,
   input  logic                          block_first,
   input  logic [CHAN_W-1:0]             channel_id,
   input  logic [BASE_W-1:0]             block_base,
   output logic                          evt_push,
   output logic [CHAN_W-1:0]             evt_channel,
   output logic [BASE_W-1:0]             evt_base,
   output logic [POS_W-1:0]              evt_prev_pos,
   output logic [POS_W-1:0]              evt_pos,
   output logic signed [SAMPLE_BITS-1:0] evt_prev_value,
   output logic signed [SAMPLE_BITS-1:0] evt_value
);

   localparam int IDX_W = $clog2(BLOCK_LEN + 1);

   logic [IDX_W-1:0]              idx_ff, idx_in;
   logic signed [SAMPLE_BITS-1:0] run_value_ff, run_value_in;
   logic [POS_W-1:0]              run_start_ff, run_start_in;
   logic signed [SAMPLE_BITS-1:0] left_value_ff, left_value_in;
   logic                          ext_vld_ff, ext_vld_in;
   logic                          ext_peak_ff, ext_peak_in;
   logic [POS_W-1:0]              ext_pos_ff, ext_pos_in;
   logic signed [SAMPLE_BITS-1:0] ext_value_ff, ext_value_in;
   logic [CHAN_W-1:0]             chan_ff, chan_in;
   logic [BASE_W-1:0]             base_ff, base_in;

   logic [IDX_W-1:0] idx_eff;
   logic             ext_vld_eff;
   logic [POS_W-1:0] run_start_eff;
   logic [POS_W-1:0] cur_pos;
   logic             is_peak, is_valley;
   logic [POS_W:0]   mid_sum;
   logic [POS_W-1:0] mid;

   // Block start restarts indexing and forgets the previous extremum
   assign idx_eff       = block_first ? '0 : idx_ff;
   assign ext_vld_eff   = block_first ? 1'b0 : ext_vld_ff;
   assign run_start_eff = block_first ? '0 : run_start_ff;
   assign cur_pos       = idx_eff[POS_W-1:0];

   assign is_peak   = (run_value_ff > left_value_ff) && (run_value_ff > sample);
   assign is_valley = (run_value_ff < left_value_ff) && (run_value_ff < sample);
   assign mid_sum   = {1'b0, run_start_eff} + {1'b0, cur_pos} - 1'b1;
   assign mid       = mid_sum[POS_W:1];

   assign evt_channel    = chan_in;
   assign evt_base       = base_in;
   assign evt_prev_pos   = ext_pos_ff;
   assign evt_pos        = mid;
   assign evt_prev_value = ext_value_ff;
   assign evt_value      = run_value_ff;

   always_comb begin
      idx_in        = idx_ff;
      run_value_in  = run_value_ff;
      run_start_in  = run_start_eff;
      left_value_in = left_value_ff;
      ext_vld_in    = ext_vld_eff;
      ext_peak_in   = ext_peak_ff;
      ext_pos_in    = ext_pos_ff;
      ext_value_in  = ext_value_ff;
      chan_in       = block_first ? channel_id : chan_ff;
      base_in       = block_first ? block_base : base_ff;
      evt_push      = 1'b0;
      if (block_first) begin
         idx_in = '0;
      end
      // Drop samples past the end of the block
      if (idx_eff < IDX_W'(BLOCK_LEN)) begin
         idx_in = idx_eff + 1'b1;
         if (idx_eff == '0) begin
            run_value_in = sample;
            run_start_in = '0;
         end else if (sample != run_value_ff) begin
            if ((run_start_eff != '0) && (is_peak || is_valley)) begin
               // Opposite type to the previous extremum: hand the pair to the back
               evt_push     = accept && ext_vld_eff && (ext_peak_ff != is_peak);
               ext_vld_in   = 1'b1;
               ext_peak_in  = is_peak;
               ext_pos_in   = mid;
               ext_value_in = run_value_ff;
            end
            left_value_in = run_value_ff;
            run_value_in  = sample;
            run_start_in  = cur_pos;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff        <= '0;
         run_value_ff  <= '0;
         run_start_ff  <= '0;
         left_value_ff <= '0;
         ext_vld_ff    <= 1'b0;
         ext_peak_ff   <= 1'b0;
         ext_pos_ff    <= '0;
         ext_value_ff  <= '0;
         chan_ff       <= '0;
         base_ff       <= '0;
      end else if (accept) begin
         idx_ff        <= idx_in;
         run_value_ff  <= run_value_in;
         run_start_ff  <= run_start_in;
         left_value_ff <= left_value_in;
         ext_vld_ff    <= ext_vld_in;
         ext_peak_ff   <= ext_peak_in;
         ext_pos_ff    <= ext_pos_in;
         ext_value_ff  <= ext_value_in;
         chan_ff       <= chan_in;
         base_ff       <= base_in;
      end
   end

endmodule

// File: hdl/ped_back.sv
module ped_back import ped_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   parameter int POS_W       = 13
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [0:0]                    csr_index,
   input  logic [CSR_W-1:0]              csr_wdata,
   input  logic                          evt_vld,
   input  logic [CHAN_W-1:0]             evt_channel,
   input  logic [BASE_W-1:0]             evt_base,
   input  logic [POS_W-1:0]              evt_prev_pos,
   input  logic [POS_W-1:0]              evt_pos,
   input  logic signed [SAMPLE_BITS-1:0] evt_prev_value,
   input  logic signed [SAMPLE_BITS-1:0] evt_value,
   output logic                          evt_pop,
   output logic                          rsp_vld,
   input  logic                          rsp_pop,
   output logic [CHAN_W-1:0]             rsp_cand_channel,
   output logic [BASE_W-1:0]             rsp_start_index,
   output logic [BASE_W-1:0]             rsp_end_index,
   output logic [P2P_W-1:0]              rsp_peak_to_peak
);

   localparam int MAG_W = (SAMPLE_BITS > P2P_W) ? SAMPLE_BITS : P2P_W;
   localparam int SP_W  = (POS_W > SPACING_W) ? POS_W : SPACING_W;

   logic [P2P_W-1:0]     min_p2p_ff;
   logic [SPACING_W-1:0] min_spacing_ff;
   logic                 out_vld_ff, out_vld_in;
   logic [CHAN_W-1:0]    out_chan_ff;
   logic [BASE_W-1:0]    out_start_ff, out_end_ff;
   logic [P2P_W-1:0]     out_p2p_ff;

   logic                 take;
   logic [SAMPLE_BITS:0] diff, diff_abs;
   logic [MAG_W-1:0]     mag;
   logic [SP_W-1:0]      pos_gap;
   logic                 keep;
   logic [P2P_W-1:0]     p2p_sat;
   csr_index_type        csr_sel;

   assign csr_sel = csr_index_type'(csr_index);

   // Advance whenever the output register is free or being drained
   assign take    = !out_vld_ff || rsp_pop;
   assign evt_pop = take && evt_vld;

   assign diff     = {evt_value[SAMPLE_BITS-1], evt_value}
                   - {evt_prev_value[SAMPLE_BITS-1], evt_prev_value};
   assign diff_abs = diff[SAMPLE_BITS] ? (~diff + 1'b1) : diff;
   assign mag      = MAG_W'(diff_abs[SAMPLE_BITS-1:0]);
   assign pos_gap  = SP_W'(evt_pos - evt_prev_pos);
   assign keep     = (mag >= MAG_W'(min_p2p_ff)) && (pos_gap > SP_W'(min_spacing_ff));
   assign p2p_sat  = (mag > MAG_W'({P2P_W{1'b1}})) ? {P2P_W{1'b1}} : mag[P2P_W-1:0];

   always_comb begin
      out_vld_in = out_vld_ff;
      if (take) begin
         out_vld_in = evt_vld && keep;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff     <= 1'b0;
         min_p2p_ff     <= '0;
         min_spacing_ff <= '0;
      end else begin
         out_vld_ff <= out_vld_in;
         if (csr_we) begin
            unique case (csr_sel)
               CSR_MIN_P2P: begin
                  min_p2p_ff <= csr_wdata;
               end
               CSR_MIN_SPACING: begin
                  min_spacing_ff <= csr_wdata[SPACING_W-1:0];
               end
               default: begin
                  min_p2p_ff <= min_p2p_ff;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take && evt_vld) begin
         out_chan_ff  <= evt_channel;
         out_start_ff <= evt_base + BASE_W'(evt_prev_pos);
         out_end_ff   <= evt_base + BASE_W'(evt_pos);
         out_p2p_ff   <= p2p_sat;
      end
   end

   assign rsp_vld          = out_vld_ff;
   assign rsp_cand_channel = out_chan_ff;
   assign rsp_start_index  = out_start_ff;
   assign rsp_end_index    = out_end_ff;
   assign rsp_peak_to_peak = out_p2p_ff;

endmodule

// File: dv/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import ped_pkg::*;

   localparam int SB           = SAMPLE_BITS_DEF;
   localparam int BLOCK_LEN    = BLOCK_LEN_DEF;
   // A candidate passes the event queue and the output register; leave margin for the queue.
   localparam int DRAIN_CYCLES = 8;
   // Receiver hold-off long enough to fill the event queue and back up req_full.
   localparam int LONG_HOLD    = 400;
   // Longest honest quiet spell is the long hold plus a long gap; take it many times over.
   localparam int WATCHDOG     = 4000;

   typedef struct packed {
      logic [SB-1:0]     sample;
      logic              first;
      logic [CHAN_W-1:0] chan;
      logic [BASE_W-1:0] base;
   } sample_word_type;

   typedef struct packed {
      logic [CHAN_W-1:0] chan;
      logic [BASE_W-1:0] start_idx;
      logic [BASE_W-1:0] end_idx;
      logic [P2P_W-1:0]  p2p;
   } candidate_type;

   // ------------------------------------------------------------------
   // Clock, reset and DUT pins; every input starts at a known value.
   // ------------------------------------------------------------------
   logic              clock           = 1'b0;
   logic              reset           = 1'b1;
   logic              req_push        = 1'b0;
   logic              req_full;
   logic [SB-1:0]     req_sample      = '0;
   logic              req_block_first = 1'b0;
   logic [CHAN_W-1:0] req_channel_id  = '0;
   logic [BASE_W-1:0] req_block_base  = '0;
   logic              rsp_empty;
   logic              rsp_pop         = 1'b0;
   logic [CHAN_W-1:0] rsp_cand_channel;
   logic [BASE_W-1:0] rsp_start_index;
   logic [BASE_W-1:0] rsp_end_index;
   logic [P2P_W-1:0]  rsp_peak_to_peak;
   logic              csr_we          = 1'b0;
   logic [0:0]        csr_index       = CSR_MIN_P2P;
   logic [CSR_W-1:0]  csr_wdata       = '0;

   always #10 clock = ~clock;

   plateau_extrema_pair_detector u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_sample       (req_sample),
      .req_block_first  (req_block_first),
      .req_channel_id   (req_channel_id),
      .req_block_base   (req_block_base),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_cand_channel (rsp_cand_channel),
      .rsp_start_index  (rsp_start_index),
      .rsp_end_index    (rsp_end_index),
      .rsp_peak_to_peak (rsp_peak_to_peak),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   // ------------------------------------------------------------------
   // Plateau tracker: our own copy of the block's state and thresholds.
   // ------------------------------------------------------------------
   logic [13:0]              blk_idx     = '0;   // saturates at BLOCK_LEN
   logic signed [SB-1:0]     plat_value  = '0;
   logic [SPACING_W-1:0]     plat_start  = '0;
   logic signed [SB-1:0]     left_value  = '0;
   bit                       ext_valid   = 1'b0;
   bit                       ext_is_peak = 1'b0;
   logic [SPACING_W-1:0]     ext_pos     = '0;
   logic signed [SB-1:0]     ext_value   = '0;
   logic [CHAN_W-1:0]        blk_chan    = '0;
   logic [BASE_W-1:0]        blk_base    = '0;
   logic [P2P_W-1:0]         min_p2p     = '0;
   logic [SPACING_W-1:0]     min_spacing = '0;

   sample_word_type sample_backlog[$];   // words waiting for the driver
   candidate_type   cand_expected[$];    // candidates the block still owes us

   sample_word_type cur_word;
   int words_queued = 0;
   int words_taken  = 0;
   int cands_seen   = 0;
   int mismatches   = 0;

   // Advance the tracker by one accepted sample word; queue any candidate it yields.
   function automatic void track_sample(sample_word_type w);
      int i, mid, diff;
      bit is_peak, is_valley;
      candidate_type c;
      if (w.first) begin
         blk_idx    = '0;
         ext_valid  = 1'b0;
         plat_start = '0;
         blk_chan   = w.chan;
         blk_base   = w.base;
      end
      // Past the end of the block: drop the word until the next block start.
      if (blk_idx >= BLOCK_LEN) return;
      i = int'(blk_idx);
      if (i == 0) begin
         plat_value = w.sample;
         plat_start = '0;
      end else if (w.sample != plat_value) begin
         // A plateau touching the block start has no left neighbour.
         if (plat_start != 0) begin
            is_peak   = plat_value > left_value && plat_value > $signed(w.sample);
            is_valley = plat_value < left_value && plat_value < $signed(w.sample);
            if (is_peak || is_valley) begin
               mid = (int'(plat_start) + i - 1) / 2;
               if (ext_valid && ext_is_peak != is_peak) begin
                  diff = int'(plat_value) - int'(ext_value);
                  if (diff < 0) diff = -diff;
                  if (diff >= int'(min_p2p) && (mid - int'(ext_pos)) > int'(min_spacing)) begin
                     c.chan      = blk_chan;
                     c.start_idx = blk_base + BASE_W'(ext_pos);
                     c.end_idx   = blk_base + BASE_W'(mid);
                     c.p2p       = P2P_W'(diff);
                     cand_expected.push_back(c);
                  end
               end
               ext_valid   = 1'b1;
               ext_is_peak = is_peak;
               ext_pos     = SPACING_W'(mid);
               ext_value   = plat_value;
            end
         end
         left_value = plat_value;
         plat_value = w.sample;
         plat_start = SPACING_W'(i);
      end
      blk_idx = 14'(i + 1);
   endfunction

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [BASE_W-1:0] pick_base();
      int r;
      r = $urandom_range(0, 7);
      // Bases near the top of the range make the indices wrap.
      if (r < 2) return {BASE_W{1'b1}} - BASE_W'($urandom_range(0, 20000));
      if (r == 2) return BASE_W'($urandom_range(0, 1000));
      return {8'($urandom), 32'($urandom)};
   endfunction

   // ------------------------------------------------------------------
   // Sender: feed the backlog to the req port, one word per handshake.
   // ------------------------------------------------------------------
   int push_gap    = 0;
   int push_steady = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         if (req_push && !req_full) begin
            track_sample(cur_word);
            words_taken++;
         end
         // Move on only when nothing is offered or the offered word just went in.
         if (!req_push || !req_full) begin
            if (push_gap > 0) begin
               push_gap--;
               req_push <= 1'b0;
            end else if (sample_backlog.size() != 0) begin
               cur_word = sample_backlog.pop_front();
               req_push        <= 1'b1;
               req_sample      <= cur_word.sample;
               req_block_first <= cur_word.first;
               req_channel_id  <= cur_word.chan;
               req_block_base  <= cur_word.base;
               if (push_steady > 0) begin
                  push_steady--;
               end else begin
                  push_gap = pick_gap();
                  if ($urandom_range(0, 63) == 0) push_steady = $urandom_range(40, 150);
               end
            end else begin
               req_push <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Receiver: random pop pattern, plus one long hold-off to back up the block.
   // ------------------------------------------------------------------
   int  pop_wait   = 0;
   int  pop_steady = 0;
   bit  hold_done  = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (!hold_done && cands_seen >= 40) begin
            hold_done = 1'b1;
            pop_wait  = LONG_HOLD;
         end
         if (pop_wait > 0) begin
            pop_wait--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
            if (pop_steady > 0) begin
               pop_steady--;
            end else begin
               pop_wait = ($urandom_range(0, 2) == 0) ? pick_gap() : 0;
               if ($urandom_range(0, 63) == 0) pop_steady = $urandom_range(40, 150);
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Monitor: compare every popped candidate with the oldest one owed.
   // ------------------------------------------------------------------
   function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         mismatches++;
         $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
      end
   endfunction

   always @(posedge clock) begin
      candidate_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         cands_seen++;
         if (cand_expected.size() == 0) begin
            mismatches++;
            $display("%0t ns: candidate with none owed, expected nothing, got ch 0x%0h %0h..%0h p2p %0d",
                     $time, rsp_cand_channel, rsp_start_index, rsp_end_index, rsp_peak_to_peak);
         end else begin
            want = cand_expected.pop_front();
            check_field("cand_channel", 64'(want.chan), 64'(rsp_cand_channel));
            check_field("start_index", 64'(want.start_idx), 64'(rsp_start_index));
            check_field("end_index", 64'(want.end_idx), 64'(rsp_end_index));
            check_field("peak_to_peak", 64'(want.p2p), 64'(rsp_peak_to_peak));
         end
      end
   end

   // ------------------------------------------------------------------
   // Watchdog: end the run if neither side moves for too long.
   // ------------------------------------------------------------------
   int idle_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty) || csr_we) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG) begin
            $display("%0t ns: watchdog, no word moved for %0d cycles, %0d candidates owed",
                     $time, WATCHDOG, cand_expected.size());
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------

   // Queue one sample word. Channel and base only count on a block start, so
   // hand other words random junk there to prove it is ignored.
   task automatic queue_word(int value, bit first, logic [CHAN_W-1:0] chan,
                             logic [BASE_W-1:0] base);
      sample_word_type w;
      w.sample = SB'(value);
      w.first  = first;
      w.chan   = first ? chan : CHAN_W'($urandom);
      w.base   = first ? base : {8'($urandom), 32'($urandom)};
      sample_backlog.push_back(w);
      words_queued++;
   endtask

   // One block of plateaus that zigzag with random widths and step sizes.
   // A noisy block throws in stray block starts and jumps across the full range.
   task automatic queue_block(int len, bit noisy);
      int value, width, dir, step, r, k;
      logic [CHAN_W-1:0] chan;
      logic [BASE_W-1:0] base;
      chan  = CHAN_W'($urandom);
      base  = pick_base();
      value = int'($urandom_range(0, 65535)) - 32768;
      dir   = 1;
      k     = 0;
      while (k < len) begin
         width = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 5) : 1;
         for (int j = 0; j < width && k < len; j++) begin
            queue_word(value, k == 0 || (noisy && $urandom_range(0, 7) == 0), chan, base);
            k++;
         end
         if ($urandom_range(0, 2) != 0) dir = -dir;
         r = $urandom_range(0, 99);
         if (noisy && r < 30) begin
            value = int'($urandom_range(0, 65535)) - 32768;
         end else begin
            if (r < 80) step = $urandom_range(1, 400);
            else if (r < 95) step = $urandom_range(401, 8000);
            else step = $urandom_range(8001, 65535);
            value = value + dir * step;
            if (value > 32767) value = 32767;
            if (value < -32768) value = -32768;
         end
      end
   endtask

   // Random blocks until about count more words are queued; most blocks are short.
   task automatic queue_random_words(int count);
      int stop_at, r, len;
      stop_at = words_queued + count;
      while (words_queued < stop_at) begin
         r = $urandom_range(0, 99);
         if (r < 10) len = $urandom_range(0, 2);
         else if (r < 95) len = $urandom_range(3, 40);
         else len = $urandom_range(41, 200);
         queue_block(len, $urandom_range(0, 9) == 0);
      end
   endtask

   // One block of len words: square wave with jittered widths and levels,
   // so spacing and peak-to-peak sit right around the thresholds.
   task automatic queue_square_block(int len);
      int k, width, level;
      bit high;
      logic [CHAN_W-1:0] chan;
      logic [BASE_W-1:0] base;
      chan = CHAN_W'($urandom);
      base = pick_base();
      k    = 0;
      high = 1'b0;
      while (k < len) begin
         width = $urandom_range(28, 36);
         level = high ? 100 + int'($urandom_range(0, 3)) : -100 - int'($urandom_range(0, 3));
         for (int j = 0; j < width && k < len; j++) begin
            queue_word(level, k == 0, chan, base);
            k++;
         end
         high = !high;
      end
   endtask

   // Hold until every word went in and every candidate came out, then let the
   // pipeline settle since a word can leave nothing behind.
   task automatic wait_drained();
      while (words_taken != words_queued || cand_expected.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write both thresholds while idle; junk the spare upper bits of the spacing write.
   task automatic write_thresholds(logic [P2P_W-1:0] p2p, logic [SPACING_W-1:0] spacing);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_MIN_P2P;
      csr_wdata <= p2p;
      @(posedge clock);
      csr_index <= CSR_MIN_SPACING;
      csr_wdata <= {3'($urandom), spacing};
      @(posedge clock);
      csr_we    <= 1'b0;
      min_p2p     = p2p;
      min_spacing = spacing;
   endtask

   // ------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------
   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // No block start after reset: channel 0, base 0, a peak then two pairs.
      queue_word(5, 1'b0, '0, '0);
      queue_word(10, 1'b0, '0, '0);
      queue_word(10, 1'b0, '0, '0);
      queue_word(3, 1'b0, '0, '0);
      queue_word(8, 1'b0, '0, '0);
      queue_word(-2, 1'b0, '0, '0);
      // Full-scale swings on a base that wraps; the closing plateau at the end
      // of the block never counts.
      queue_word(7, 1'b1, 8'hA5, 40'hFF_FFFF_FFFE);
      queue_word(-32768, 1'b0, '0, '0);
      queue_word(-32768, 1'b0, '0, '0);
      queue_word(32767, 1'b0, '0, '0);
      queue_word(-32768, 1'b0, '0, '0);
      queue_word(32767, 1'b0, '0, '0);
      queue_word(32767, 1'b0, '0, '0);
      // Two-sample block, then a lone peak that must not pair across blocks.
      queue_word(1, 1'b1, 8'h03, 40'd100);
      queue_word(9, 1'b0, '0, '0);
      queue_word(0, 1'b1, 8'hFF, 40'h55_5555_5555);
      queue_word(5, 1'b0, '0, '0);
      queue_word(0, 1'b0, '0, '0);
      // Plateau on the block start, then one on the block end.
      queue_word(4, 1'b1, 8'h00, {BASE_W{1'b1}});
      queue_word(4, 1'b0, '0, '0);
      queue_word(4, 1'b0, '0, '0);
      queue_word(1, 1'b0, '0, '0);
      queue_word(2, 1'b0, '0, '0);
      queue_word(2, 1'b0, '0, '0);
      wait_drained();

      // Lowest thresholds: nearly every opposite pair is a candidate.
      write_thresholds('0, '0);
      queue_random_words(350);
      wait_drained();

      // Highest thresholds: no pair can ever qualify.
      write_thresholds({P2P_W{1'b1}}, {SPACING_W{1'b1}});
      queue_random_words(120);
      wait_drained();

      // Full peak-to-peak needed; only rail-to-rail swings get through.
      write_thresholds({P2P_W{1'b1}}, '0);
      queue_word(-32768, 1'b1, 8'h5A, pick_base());
      queue_word(32767, 1'b0, '0, '0);
      queue_word(-32768, 1'b0, '0, '0);
      queue_word(32767, 1'b0, '0, '0);
      queue_word(0, 1'b0, '0, '0);
      queue_random_words(60);
      wait_drained();

      write_thresholds(P2P_W'($urandom_range(0, 3000)), SPACING_W'($urandom_range(0, 12)));
      queue_random_words(250);
      wait_drained();

      // Thresholds on the edge of the square wave's spacing and swing.
      write_thresholds(16'd203, 13'd31);
      queue_square_block(200);
      wait_drained();

      write_thresholds(P2P_W'($urandom_range(0, 1000)), SPACING_W'($urandom_range(0, 6)));
      queue_random_words(150);
      wait_drained();

      if (mismatches == 0 && cand_expected.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// File: plateau_extrema_pair_detector.f
hdl/ped_pkg.sv
hdl/ped_queue.sv
hdl/ped_front.sv
hdl/ped_back.sv
hdl/plateau_extrema_pair_detector.sv
dv/tb_top.sv
